/* hdl/jms_pkg.sv */
// ----------------------------------------------------------------------------
// jms_pkg
// Types, constants and helpers shared by the JPEG marker scanner.
// ----------------------------------------------------------------------------
package jms_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int MAX_EVENTS  = 3;
  localparam int CNT_BITS    = $clog2(MAX_EVENTS + 1);

  localparam logic [7:0] BYTE_FF  = 8'hff;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] CODE_SOI = 8'hd8;
  localparam logic [7:0] CODE_EOI = 8'hd9;
  localparam logic [7:0] CODE_COM = 8'hfe;

  typedef enum logic [1:0] {
    CFG_REPORT_MARKERS = 2'd0,
    CFG_PASS_COMMENT   = 2'd1,
    CFG_PASS_TAIL      = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    EV_MARKER  = 3'd0,
    EV_ENTROPY = 3'd1,
    EV_COMMENT = 3'd2,
    EV_TAIL    = 3'd3,
    EV_SUMMARY = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_JPEG  = 2'd1,
    ST_TRUNC_LEN = 2'd2,
    ST_TRUNC_PAY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    M_MAGIC0    = 4'd0,
    M_MAGIC1    = 4'd1,
    M_SEEK      = 4'd2,
    M_TAG       = 4'd3,
    M_DATA      = 4'd4,
    M_LENHI     = 4'd5,
    M_LENLO     = 4'd6,
    M_PAYLOAD   = 4'd7,
    M_TAILFIRST = 4'd8,
    M_TAIL      = 4'd9,
    M_REJECT    = 4'd10
  } mode_t;

  typedef struct packed {
    logic       report_markers;
    logic       pass_comment;
    logic       pass_tail;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  value;
    logic [31:0] comment_start;
    logic [16:0] comment_length;
    logic [31:0] tail_start;
    logic [1:0]  status;
    logic        last;
  } event_item_t;

  typedef struct packed {
    event_item_t [MAX_EVENTS-1:0] item;
    logic [CNT_BITS-1:0]          count;
  } event_group_t;

  function automatic logic has_length(input logic [7:0] m);
    return (m >= 8'h02 && m <= 8'h0f) || (m >= 8'ha0 && m <= 8'hcf) ||
           (m >= 8'hda && m <= 8'hfe);
  endfunction

endpackage

/* hdl/jms_if.sv */
// ----------------------------------------------------------------------------
// jms stream interfaces
// Valid/ready channels for file bytes in and scanner events out.
// ----------------------------------------------------------------------------
interface jms_byte_if import jms_pkg::*; ();
  logic       valid;
  logic       ready;
  byte_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface jms_event_if import jms_pkg::*; ();
  logic        valid;
  logic        ready;
  event_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/jms_parser.sv */
// ----------------------------------------------------------------------------
// jms_parser
// Marker/length/payload state machine; builds the event group for one byte.
// ----------------------------------------------------------------------------
module jms_parser import jms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_file,
  output event_group_t           group
);

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [15:0]            bytes_remaining, bytes_remaining_next;
  logic [7:0]             length_high, length_high_next;
  logic [7:0]             current_marker, current_marker_next;
  logic                   last_report_was_data, last_report_was_data_next;
  logic [OFFSET_BITS-1:0] comment_offset, comment_offset_next;
  logic [16:0]            comment_len, comment_len_next;
  logic [OFFSET_BITS-1:0] tail_offset, tail_offset_next;
  logic [1:0]             error_status, error_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= M_MAGIC0;
      byte_offset          <= '0;
      bytes_remaining      <= '0;
      length_high          <= '0;
      current_marker       <= '0;
      last_report_was_data <= 1'b0;
      comment_offset       <= '0;
      comment_len          <= '0;
      tail_offset          <= '0;
      error_status         <= '0;
    end else if (accept) begin
      mode                 <= mode_next;
      byte_offset          <= byte_offset_next;
      bytes_remaining      <= bytes_remaining_next;
      length_high          <= length_high_next;
      current_marker       <= current_marker_next;
      last_report_was_data <= last_report_was_data_next;
      comment_offset       <= comment_offset_next;
      comment_len          <= comment_len_next;
      tail_offset          <= tail_offset_next;
      error_status         <= error_status_next;
    end
  end

  logic [15:0]         decl;
  logic [15:0]         remaining_dec;
  mode_t               seg_end_mode;
  logic [CNT_BITS-1:0] n;
  status_t             st;
  event_item_t         ev;

  assign decl          = {length_high, data_byte};
  assign remaining_dec = (bytes_remaining != '0) ? bytes_remaining - 16'd1 : bytes_remaining;
  assign seg_end_mode  = (current_marker == CODE_EOI) ? M_TAILFIRST : M_SEEK;

  always_comb begin
    mode_next                 = mode;
    bytes_remaining_next      = bytes_remaining;
    length_high_next          = length_high;
    current_marker_next       = current_marker;
    last_report_was_data_next = last_report_was_data;
    comment_offset_next       = comment_offset;
    comment_len_next          = comment_len;
    tail_offset_next          = tail_offset;
    error_status_next         = error_status;
    byte_offset_next = (&byte_offset) ? byte_offset : byte_offset + 1'b1;
    group = '0;
    n     = '0;
    ev    = '0;
    st    = ST_OK;

    case (mode)
      M_MAGIC0: begin
        if (data_byte == BYTE_FF) begin
          mode_next = M_MAGIC1;
        end else begin
          mode_next         = M_REJECT;
          error_status_next = ST_NOT_JPEG;
        end
      end
      M_MAGIC1: begin
        if (data_byte == CODE_SOI) begin
          if (cfg.report_markers) begin
            ev = '0;
            ev.event_kind = EV_MARKER;
            ev.value      = data_byte;
            group.item[n] = ev;
            n = n + 1'b1;
          end
          last_report_was_data_next = 1'b0;
          current_marker_next       = data_byte;
          mode_next                 = M_SEEK;
        end else begin
          mode_next         = M_REJECT;
          error_status_next = ST_NOT_JPEG;
        end
      end
      M_SEEK: begin
        if (data_byte == BYTE_FF) begin
          mode_next = M_TAG;
        end else begin
          if (!last_report_was_data && cfg.report_markers) begin
            ev = '0;
            ev.event_kind = EV_ENTROPY;
            ev.value      = data_byte;
            group.item[n] = ev;
            n = n + 1'b1;
          end
          last_report_was_data_next = 1'b1;
          mode_next                 = M_DATA;
        end
      end
      M_TAG: begin
        if (data_byte != BYTE_00 && data_byte != BYTE_FF) begin
          if (cfg.report_markers) begin
            ev = '0;
            ev.event_kind = EV_MARKER;
            ev.value      = data_byte;
            group.item[n] = ev;
            n = n + 1'b1;
          end
          last_report_was_data_next = 1'b0;
          current_marker_next       = data_byte;
          if (data_byte == CODE_COM) comment_offset_next = byte_offset;
          if (has_length(data_byte)) mode_next = M_LENHI;
          else mode_next = (data_byte == CODE_EOI) ? M_TAILFIRST : M_SEEK;
        end else begin
          mode_next = M_DATA;
        end
      end
      M_DATA: begin
        if (data_byte == BYTE_FF) mode_next = M_TAG;
      end
      M_LENHI: begin
        length_high_next = data_byte;
        mode_next        = M_LENLO;
      end
      M_LENLO: begin
        if (current_marker == CODE_COM) comment_len_next = {1'b0, decl} + 17'd2;
        if (decl > 16'd2) begin
          bytes_remaining_next = decl - 16'd2;
          mode_next            = M_PAYLOAD;
        end else begin
          mode_next = seg_end_mode;
        end
      end
      M_PAYLOAD: begin
        if (current_marker == CODE_COM && cfg.pass_comment) begin
          ev = '0;
          ev.event_kind = EV_COMMENT;
          ev.value      = data_byte;
          group.item[n] = ev;
          n = n + 1'b1;
        end
        bytes_remaining_next = remaining_dec;
        if (remaining_dec == '0) mode_next = seg_end_mode;
      end
      M_TAILFIRST: begin
        tail_offset_next = byte_offset;
        if (!last_report_was_data && cfg.report_markers) begin
          ev = '0;
          ev.event_kind = EV_ENTROPY;
          ev.value      = data_byte;
          group.item[n] = ev;
          n = n + 1'b1;
        end
        last_report_was_data_next = 1'b1;
        if (cfg.pass_tail) begin
          ev = '0;
          ev.event_kind = EV_TAIL;
          ev.value      = data_byte;
          group.item[n] = ev;
          n = n + 1'b1;
        end
        mode_next = M_TAIL;
      end
      M_TAIL: begin
        if (cfg.pass_tail) begin
          ev = '0;
          ev.event_kind = EV_TAIL;
          ev.value      = data_byte;
          group.item[n] = ev;
          n = n + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (end_of_file) begin
      if (error_status_next != '0 || mode_next == M_MAGIC1 || mode_next == M_REJECT) begin
        st = ST_NOT_JPEG;
      end else if (mode_next == M_LENHI || mode_next == M_LENLO) begin
        st = ST_TRUNC_LEN;
      end else if (mode_next == M_PAYLOAD) begin
        st = ST_TRUNC_PAY;
      end else begin
        st = ST_OK;
      end
      ev = '0;
      ev.event_kind     = EV_SUMMARY;
      ev.comment_start  = 32'(comment_offset_next);
      ev.comment_length = comment_len_next;
      ev.tail_start     = 32'(tail_offset_next);
      ev.status         = st;
      group.item[n] = ev;
      n = n + 1'b1;

      mode_next                 = M_MAGIC0;
      byte_offset_next          = '0;
      bytes_remaining_next      = '0;
      length_high_next          = '0;
      current_marker_next       = '0;
      last_report_was_data_next = 1'b0;
      comment_offset_next       = '0;
      comment_len_next          = '0;
      tail_offset_next          = '0;
      error_status_next         = '0;
    end

    group.count = n;
  end

endmodule

/* hdl/jms_event_buffer.sv */
// ----------------------------------------------------------------------------
// jms_event_buffer
// Holds the events of one byte and hands them out one per request.
// ----------------------------------------------------------------------------
module jms_event_buffer import jms_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  event_group_t group,
  input  logic         pop,
  output logic         can_load,
  output logic         valid,
  output event_item_t  head
);

  event_item_t [MAX_EVENTS-1:0] item;
  logic [CNT_BITS-1:0]          cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= group.count;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= group.item;
    end else if (pop) begin
      for (int i = 0; i < MAX_EVENTS - 1; i++) item[i] <= item[i+1];
    end
  end

  assign can_load = (cnt == '0) || (cnt == CNT_BITS'(1) && pop);
  assign valid    = (cnt != '0);

  always_comb begin
    head      = item[0];
    head.last = (cnt == CNT_BITS'(1));
  end

endmodule

/* hdl/jpeg_marker_scanner_core.sv */
// ----------------------------------------------------------------------------
// jpeg_marker_scanner_core
// JPEG marker scanner: checks the SOI magic, walks marker segments, reports
// markers, entropy-data starts, comment and tail bytes, and a file summary.
//
// Usage:
//   bytes  : one request per file byte; end_of_file marks the final byte.
//   events : zero to three requests per byte, in order; last marks the
//            final event caused by a byte. The final byte of a file always
//            yields a summary event, after which parsing restarts.
//   cfg_*  : write report_markers (0), pass_comment (1), pass_tail (2)
//            while the block is idle; other indexes are ignored.
// Latency: the first event of a byte is offered the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one event
//   and events are taken at once; else the single event port sets the pace.
// Reset (rst, synchronous): parse state and registers clear; no events held.
// A stalled events port holds the current event; bytes are taken again once
//   the last held event leaves.
// ----------------------------------------------------------------------------
module jpeg_marker_scanner_core import jms_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [0:0]    cfg_data,
  jms_byte_if.sink      bytes,
  jms_event_if.source   events
);

  cfg_t         cfg;
  event_group_t group;
  logic         accept;
  logic         pop;
  logic         can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REPORT_MARKERS: cfg.report_markers <= cfg_data[0];
        CFG_PASS_COMMENT:   cfg.pass_comment   <= cfg_data[0];
        CFG_PASS_TAIL:      cfg.pass_tail      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign pop         = events.valid & events.ready;
  assign bytes.ready = can_load;
  assign accept      = bytes.valid & can_load;

  jms_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .data_byte   (bytes.payload.data_byte),
    .end_of_file (bytes.payload.end_of_file),
    .group       (group)
  );

  jms_event_buffer u_buffer (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .group    (group),
    .pop      (pop),
    .can_load (can_load),
    .valid    (events.valid),
    .head     (events.payload)
  );

endmodule
